>>> design/pbil_pkg.sv
// shared types and constants for the particle bin index lists block
package pbil_pkg;

   localparam int DEPTH        = 5;
   localparam int BIN_CAPACITY = 64;
   localparam int INDEX_BITS   = 16;

   localparam int POS_BITS    = 32;
   localparam int BIN_BITS    = DEPTH;
   localparam int NUM_BINS    = 1 << DEPTH;
   localparam int CAP_BITS    = (BIN_CAPACITY > 1) ? $clog2(BIN_CAPACITY) : 1;
   localparam int CNT_BITS    = $clog2(BIN_CAPACITY + 1);
   localparam int ADDR_BITS   = BIN_BITS + CAP_BITS;
   localparam int LEVEL_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int MEAN_BITS   = 7;
   localparam int DELTA_BITS  = 8;
   localparam int CSR_IDX_BITS = 2;
   localparam int Q_DEPTH     = 2;
   localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

   // action codes of the request
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_CLEAR  = 2'd1;
   localparam logic [1:0] ACT_TAKE   = 2'd2;

   // register indexes of the csr port
   localparam logic [CSR_IDX_BITS-1:0] CSR_RANGE_LEFT  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RANGE_RIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MEAN        = 2'd2;

   typedef enum logic [1:0] {
      ST_OK,
      ST_OUTSIDE,
      ST_FULL,
      ST_NO_SURPLUS
   } status_type;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_REJECT,
      OP_CLEAR,
      OP_TAKE,
      OP_NOP
   } op_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_CHECK,
      FE_SEARCH,
      FE_PUSH
   } fe_state_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_EXEC,
      BE_READ
   } be_state_type;

   typedef struct packed {
      logic [1:0]                action;
      logic signed [POS_BITS-1:0] position;
      logic [15:0]               particle_index;
      logic [4:0]                target_bin;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic [4:0]                  bin_number;
      logic [6:0]                  bin_count;
      logic signed [DELTA_BITS-1:0] bin_delta;
      logic [15:0]                 index_out;
   } rsp_type;

   typedef struct packed {
      op_type                op;
      logic [BIN_BITS-1:0]   bin;
      logic [INDEX_BITS-1:0] index;
   } fe_item_type;

endpackage

>>> design/pbil_front.sv
// front end: accepts requests, checks the domain and descends to the bin
module pbil_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  pbil_pkg::req_type                req_data,
   input  logic signed [pbil_pkg::POS_BITS-1:0] range_left,
   input  logic signed [pbil_pkg::POS_BITS-1:0] range_right,
   output logic                             q_push,
   output pbil_pkg::fe_item_type            q_item,
   input  logic                             q_full
);
   import pbil_pkg::*;

   fe_state_type               state_ff, state_in;
   logic [1:0]                 action_ff, action_in;
   logic signed [POS_BITS-1:0] pos_ff, pos_in;
   logic [INDEX_BITS-1:0]      pidx_ff, pidx_in;
   logic [BIN_BITS-1:0]        tbin_ff, tbin_in;
   logic signed [POS_BITS-1:0] lo_ff, lo_in;
   logic signed [POS_BITS-1:0] hi_ff, hi_in;
   logic [BIN_BITS-1:0]        bin_ff, bin_in;
   logic [LEVEL_BITS-1:0]      level_ff, level_in;
   op_type                     op_ff, op_in;

   logic [POS_BITS:0]          mid_sum;
   logic signed [POS_BITS-1:0] mid;
   logic                       go_left;

   // floor midpoint, the sum keeps one extra bit
   assign mid_sum = {lo_ff[POS_BITS-1], lo_ff} + {hi_ff[POS_BITS-1], hi_ff};
   assign mid     = $signed(mid_sum[POS_BITS:1]);
   assign go_left = pos_ff < mid;

   assign req_stall = (state_ff != FE_IDLE);
   assign q_item    = '{op: op_ff, bin: bin_ff, index: pidx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      action_ff <= action_in;
      pos_ff    <= pos_in;
      pidx_ff   <= pidx_in;
      tbin_ff   <= tbin_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      bin_ff    <= bin_in;
      level_ff  <= level_in;
      op_ff     <= op_in;
   end

   always_comb begin
      state_in  = state_ff;
      action_in = action_ff;
      pos_in    = pos_ff;
      pidx_in   = pidx_ff;
      tbin_in   = tbin_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      bin_in    = bin_ff;
      level_in  = level_ff;
      op_in     = op_ff;
      q_push    = 1'b0;
      case (state_ff)
         FE_IDLE: begin
            if (req_valid) begin
               action_in = req_data.action;
               pos_in    = $signed(req_data.position);
               pidx_in   = req_data.particle_index[INDEX_BITS-1:0];
               tbin_in   = req_data.target_bin[BIN_BITS-1:0];
               state_in  = FE_CHECK;
            end
         end
         FE_CHECK: begin
            bin_in   = '0;
            level_in = '0;
            lo_in    = range_left;
            hi_in    = range_right;
            state_in = FE_PUSH;
            case (action_ff)
               ACT_INSERT: begin
                  if (pos_ff < range_left || pos_ff > range_right) begin
                     op_in = OP_REJECT;
                  end else begin
                     op_in    = OP_INSERT;
                     state_in = FE_SEARCH;
                  end
               end
               ACT_CLEAR: op_in = OP_CLEAR;
               ACT_TAKE: begin
                  op_in  = OP_TAKE;
                  bin_in = tbin_ff;
               end
               default: op_in = OP_NOP;
            endcase
         end
         FE_SEARCH: begin
            // one level of the descent per cycle
            if (go_left) begin
               hi_in  = mid;
               bin_in = bin_ff << 1;
            end else begin
               lo_in  = mid;
               bin_in = (bin_ff << 1) | BIN_BITS'(1);
            end
            level_in = level_ff + LEVEL_BITS'(1);
            if (level_ff == LEVEL_BITS'(DEPTH - 1)) begin
               state_in = FE_PUSH;
            end
         end
         FE_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = FE_IDLE;
            end
         end
         default: state_in = FE_IDLE;
      endcase
   end

endmodule

>>> design/pbil_queue.sv
// short queue of classified items between front and back
module pbil_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pbil_pkg::fe_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output pbil_pkg::fe_item_type head_item
);
   import pbil_pkg::*;

   fe_item_type           slots_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == Q_CNT_BITS'(Q_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slots_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + Q_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - Q_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> design/pbil_back.sv
// back end: bin counts, index list memory and result register
module pbil_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_not_empty,
   output logic                              q_pop,
   input  pbil_pkg::fe_item_type             q_item,
   input  logic [pbil_pkg::MEAN_BITS-1:0]    mean_per_bin,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output pbil_pkg::rsp_type                 rsp_data
);
   import pbil_pkg::*;

   function automatic logic signed [DELTA_BITS-1:0] delta_of(
      input logic [CNT_BITS-1:0]  cnt,
      input logic [MEAN_BITS-1:0] mean
   );
      logic [DELTA_BITS-1:0] d;
      d = DELTA_BITS'(cnt) - DELTA_BITS'(mean);
      return $signed(d);
   endfunction

   be_state_type          state_ff, state_in;
   fe_item_type           op_ff, op_in;
   logic [CNT_BITS-1:0]   counts_ff [NUM_BINS];
   logic [CNT_BITS-1:0]   new_cnt_ff, new_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [INDEX_BITS-1:0] entries [NUM_BINS * BIN_CAPACITY];
   logic [INDEX_BITS-1:0] rd_data_ff;
   logic                  mem_we, mem_re;
   logic [ADDR_BITS-1:0]  mem_addr;

   logic [CNT_BITS-1:0]   cur_cnt, dec_cnt;
   logic                  cnt_we, cnt_clear;
   logic [CNT_BITS-1:0]   cnt_wdata;
   logic                  slot_free;

   assign cur_cnt   = counts_ff[op_ff.bin];
   assign dec_cnt   = cur_cnt - CNT_BITS'(1);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      new_cnt_in   = new_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = {op_ff.bin, cur_cnt[CAP_BITS-1:0]};
      cnt_we       = 1'b0;
      cnt_clear    = 1'b0;
      cnt_wdata    = cur_cnt;
      case (state_ff)
         BE_IDLE: begin
            if (q_not_empty && slot_free) begin
               q_pop    = 1'b1;
               op_in    = q_item;
               state_in = BE_EXEC;
            end
         end
         BE_EXEC: begin
            state_in     = BE_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: ST_OK, bin_number: '0, bin_count: '0,
                             bin_delta: '0, index_out: '0};
            case (op_ff.op)
               OP_INSERT: begin
                  rsp_in.bin_number = 5'(op_ff.bin);
                  rsp_in.index_out  = 16'(op_ff.index);
                  if (cur_cnt >= CNT_BITS'(BIN_CAPACITY)) begin
                     rsp_in.status    = ST_FULL;
                     rsp_in.bin_count = 7'(cur_cnt);
                     rsp_in.bin_delta = delta_of(cur_cnt, mean_per_bin);
                  end else begin
                     // append at the list end, count goes up by one
                     mem_we    = 1'b1;
                     cnt_we    = 1'b1;
                     cnt_wdata = cur_cnt + CNT_BITS'(1);
                     rsp_in.bin_count = 7'(cnt_wdata);
                     rsp_in.bin_delta = delta_of(cnt_wdata, mean_per_bin);
                  end
               end
               OP_REJECT: begin
                  rsp_in.status    = ST_OUTSIDE;
                  rsp_in.index_out = 16'(op_ff.index);
               end
               OP_CLEAR: cnt_clear = 1'b1;
               OP_TAKE: begin
                  rsp_in.bin_number = 5'(op_ff.bin);
                  if (cur_cnt <= CNT_BITS'(mean_per_bin) || cur_cnt == '0 ||
                      cur_cnt > CNT_BITS'(BIN_CAPACITY)) begin
                     rsp_in.status    = ST_NO_SURPLUS;
                     rsp_in.bin_count = 7'(cur_cnt);
                     rsp_in.bin_delta = delta_of(cur_cnt, mean_per_bin);
                  end else begin
                     // pop the list end; result waits for the memory read
                     mem_re       = 1'b1;
                     mem_addr     = {op_ff.bin, dec_cnt[CAP_BITS-1:0]};
                     cnt_we       = 1'b1;
                     cnt_wdata    = dec_cnt;
                     new_cnt_in   = dec_cnt;
                     rsp_valid_in = 1'b0;
                     state_in     = BE_READ;
                  end
               end
               default: ;
            endcase
         end
         BE_READ: begin
            state_in     = BE_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: ST_OK, bin_number: 5'(op_ff.bin),
                             bin_count: 7'(new_cnt_ff),
                             bin_delta: delta_of(new_cnt_ff, mean_per_bin),
                             index_out: 16'(rd_data_ff)};
         end
         default: state_in = BE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BE_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_BINS; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cnt_clear) begin
            for (int i = 0; i < NUM_BINS; i++) begin
               counts_ff[i] <= '0;
            end
         end else if (cnt_we) begin
            counts_ff[op_ff.bin] <= cnt_wdata;
         end
      end
      op_ff      <= op_in;
      new_cnt_ff <= new_cnt_in;
      rsp_ff     <= rsp_in;
   end

   // index list memory, one access per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries[mem_addr] <= op_ff.index;
      end
      if (mem_re) begin
         rd_data_ff <= entries[mem_addr];
      end
   end

endmodule

>>> design/particle_bin_index_lists.sv
// top level: csr registers, front end, queue and back end of the binning block
// insert: the front steps through accept, domain check, one state per descent level and queue push,
//   and the result is registered in the back end
// clear, take surplus, rejected points: the front steps through accept, check and queue push;
//   back handles one item at a time, with an extra read state for a pop since the list memory read is registered
// synchronous reset: counts zero, registers to defaults, queue empty, list memory not cleared
module particle_bin_index_lists (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  pbil_pkg::req_type                   req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pbil_pkg::rsp_type                   rsp_data,
   // csr write port
   input  logic                                csr_we,
   input  logic [pbil_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [pbil_pkg::POS_BITS-1:0]       csr_wdata
);
   import pbil_pkg::*;

   logic signed [POS_BITS-1:0] range_left_ff, range_left_in;
   logic signed [POS_BITS-1:0] range_right_ff, range_right_in;
   logic [MEAN_BITS-1:0]       mean_ff, mean_in;

   logic        q_push, q_full, q_pop, q_not_empty;
   fe_item_type q_push_item, q_head_item;

   // csr decode, an unknown index is dropped
   always_comb begin
      range_left_in  = range_left_ff;
      range_right_in = range_right_ff;
      mean_in        = mean_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RANGE_LEFT:  range_left_in  = $signed(csr_wdata);
            CSR_RANGE_RIGHT: range_right_in = $signed(csr_wdata);
            CSR_MEAN:        mean_in        = csr_wdata[MEAN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_left_ff  <= '0;
         range_right_ff <= 32'sh7FFF_FFFF;
         mean_ff        <= MEAN_BITS'(2);
      end else begin
         range_left_ff  <= range_left_in;
         range_right_ff <= range_right_in;
         mean_ff        <= mean_in;
      end
   end

   // front: domain check and bin descent
   pbil_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .range_left  (range_left_ff),
      .range_right (range_right_ff),
      .q_push      (q_push),
      .q_item      (q_push_item),
      .q_full      (q_full)
   );

   // classified items wait here so either side can stall alone
   pbil_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (q_head_item)
   );

   // back: count update, list append or pop, result register
   pbil_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_not_empty  (q_not_empty),
      .q_pop        (q_pop),
      .q_item       (q_head_item),
      .mean_per_bin (mean_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule
